// ===== rtl/scd_pkg.sv =====
`default_nettype none

package scd_pkg;

    localparam int MAX_SOURCE_DIM = 4096;
    localparam int MAX_TARGET_DIM = 64;

    localparam int SRC_CFG_W = 13;
    localparam int TGT_CFG_W = 7;
    localparam int SRC_CNT_W = $clog2(MAX_SOURCE_DIM);
    localparam int NSP_W     = SRC_CNT_W + 1;
    localparam int TGT_CNT_W = $clog2(MAX_TARGET_DIM) + 1;
    localparam int REM_W     = TGT_CFG_W;
    localparam int CNT_PROD_W = 2 * TGT_CFG_W;

    localparam int PIXEL_W = 32;
    localparam int HASH_W  = 64;
    localparam int GRAY_W  = 8;
    localparam int BYTE_W  = 8;

    localparam int GRAY_K0 = 299;
    localparam int GRAY_K1 = 587;
    localparam int GRAY_K2 = 114;
    localparam int GRAY_DIV = 1000;
    localparam int WSUM_W = 18;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_MUL = ((2 ** RECIP_SHIFT) + GRAY_DIV - 1) / GRAY_DIV;
    localparam int RECIP_W = 19;
    localparam int PROD_W = WSUM_W + RECIP_W;

    localparam int DIV_CNT_W = $clog2(SRC_CFG_W + 1);

    localparam int RST_SW = 640;
    localparam int RST_SH = 480;
    localparam int RST_TW = 9;
    localparam int RST_TH = 8;
    localparam int RST_QW = RST_SW / RST_TW;
    localparam int RST_RW = RST_SW % RST_TW;
    localparam int RST_QH = RST_SH / RST_TH;
    localparam int RST_RH = RST_SH % RST_TH;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_TARGET_WIDTH  = 2'd2,
        CFG_TARGET_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic cfg_we;
        logic load;
        logic gray_en;
        logic update;
    } scd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic frame_end;
    } scd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/scaled_difference_hash.sv =====
// scaled_difference_hash: 64-bit difference hash of a nearest-neighbour downscaled image
//
// s_axis carries source pixels in raster order, one request per pixel; tuser marks
// the first pixel of a frame and restarts the counters and the hash. m_axis carries
// one result per frame, on the last source pixel: tdata is the hash, tuser flags an
// unusable size setup (hash then zero). cfg writes the four size registers.
// Each pixel is accepted with luma weighting, then takes the reciprocal multiply for
// the divide by 1000, then the counter and hash update, before the next pixel is
// accepted; the update waits while a frame end meets an untaken result. The result
// register and its valid are loaded by the update of the last pixel of a frame.
// A size write restarts a shared bit-serial divider for the sample steps; pixels are
// held off after the last write while it runs.
// Reset loads 640x480 to 9x8 with its divider results ready, clears all counters,
// and accepts pixels at once. A stalled result waits in the output register while
// the next pixels go on; only a further frame end waits for it to be taken.
`default_nettype none

module scaled_difference_hash (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [scd_pkg::PIXEL_W-1:0]    s_axis_tdata,   // pixel
    input  wire logic                           s_axis_tuser,   // frame_first
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [scd_pkg::HASH_W-1:0]     m_axis_tdata,   // hash
    output logic                                m_axis_tuser,   // bad_setup
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scd_pkg::SRC_CFG_W-1:0]  cfg_data
);
    import scd_pkg::*;

    scd_cmd_t cmd;
    scd_sts_t sts;

    scd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    scd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (s_axis_tdata),
        .frame_first (s_axis_tuser),
        .hash        (m_axis_tdata),
        .bad_setup   (m_axis_tuser)
    );

    a_bad_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad setup result with nonzero hash");

    a_result_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && sts.frame_end |=> m_axis_tvalid)
        else $error("frame end did not raise a result");

    a_no_pixel_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> sts.div_done)
        else $error("pixel taken while divider busy");

    a_cfg_blocks_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready)
        else $error("pixel taken right after size write");

endmodule

`default_nettype wire

// ===== rtl/scd_div.sv =====
`default_nettype none

module scd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [scd_pkg::SRC_CFG_W-1:0]  dividend_a,
    input  wire logic [scd_pkg::TGT_CFG_W-1:0]  divisor_a,
    input  wire logic [scd_pkg::SRC_CFG_W-1:0]  dividend_b,
    input  wire logic [scd_pkg::TGT_CFG_W-1:0]  divisor_b,
    output logic      [scd_pkg::SRC_CFG_W-1:0]  quot_a,
    output logic      [scd_pkg::REM_W-1:0]      rem_a,
    output logic      [scd_pkg::SRC_CFG_W-1:0]  quot_b,
    output logic      [scd_pkg::REM_W-1:0]      rem_b,
    output logic                                done
);
    import scd_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SRC_CFG_W-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [REM_W-1:0]     ra_reg, ra_next, rb_reg, rb_next;
    logic [DIV_CNT_W-1:0] bit_idx;
    logic [REM_W:0]       ra_shift, rb_shift;
    logic                 ra_ge, rb_ge;

    assign done    = cnt_reg == DIV_CNT_W'(SRC_CFG_W);
    assign bit_idx = DIV_CNT_W'(SRC_CFG_W - 1) - cnt_reg;

    // one quotient bit per cycle, msb first
    always_comb
    begin
        ra_shift = {ra_reg, dividend_a[bit_idx]};
        rb_shift = {rb_reg, dividend_b[bit_idx]};
        ra_ge    = ra_shift >= {1'b0, divisor_a};
        rb_ge    = rb_shift >= {1'b0, divisor_b};
        cnt_next = cnt_reg;
        qa_next  = qa_reg;
        qb_next  = qb_reg;
        ra_next  = ra_reg;
        rb_next  = rb_reg;
        if (start)
        begin
            cnt_next = '0;
            qa_next  = '0;
            qb_next  = '0;
            ra_next  = '0;
            rb_next  = '0;
        end
        else if (!done)
        begin
            cnt_next = cnt_reg + 1'b1;
            qa_next  = {qa_reg[SRC_CFG_W-2:0], ra_ge};
            qb_next  = {qb_reg[SRC_CFG_W-2:0], rb_ge};
            ra_next  = ra_ge ? REM_W'(ra_shift - {1'b0, divisor_a}) : ra_shift[REM_W-1:0];
            rb_next  = rb_ge ? REM_W'(rb_shift - {1'b0, divisor_b}) : rb_shift[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= DIV_CNT_W'(SRC_CFG_W);
            qa_reg  <= SRC_CFG_W'(RST_QW);
            ra_reg  <= REM_W'(RST_RW);
            qb_reg  <= SRC_CFG_W'(RST_QH);
            rb_reg  <= REM_W'(RST_RH);
        end
        else
        begin
            cnt_reg <= cnt_next;
            qa_reg  <= qa_next;
            ra_reg  <= ra_next;
            qb_reg  <= qb_next;
            rb_reg  <= rb_next;
        end
    end

    assign quot_a = qa_reg;
    assign rem_a  = ra_reg;
    assign quot_b = qb_reg;
    assign rem_b  = rb_reg;

endmodule

`default_nettype wire

// ===== rtl/scd_dp.sv =====
`default_nettype none

module scd_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire scd_pkg::scd_cmd_t              cmd,
    output scd_pkg::scd_sts_t                   sts,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scd_pkg::SRC_CFG_W-1:0]  cfg_data,
    input  wire logic [scd_pkg::PIXEL_W-1:0]    pixel,
    input  wire logic                           frame_first,
    output logic      [scd_pkg::HASH_W-1:0]     hash,
    output logic                                bad_setup
);
    import scd_pkg::*;

    logic [SRC_CFG_W-1:0] sw_reg, sh_reg;
    logic [TGT_CFG_W-1:0] tw_reg, th_reg;

    logic [SRC_CFG_W-1:0] quot_w, quot_h;
    logic [REM_W-1:0]     rem_w, rem_h;

    logic [WSUM_W-1:0] wsum_reg;
    logic              first_reg;
    logic [PROD_W-1:0] prod;
    logic [GRAY_W-1:0] gray_reg;

    logic [SRC_CNT_W-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [TGT_CNT_W-1:0] tcol_reg, tcol_next, trow_reg, trow_next;
    logic [NSP_W-1:0]     nsc_reg, nsc_next, nsr_reg, nsr_next;
    logic [REM_W-1:0]     crem_reg, crem_next, rrem_reg, rrem_next;
    logic [GRAY_W-1:0]    prev_reg, prev_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;

    logic [SRC_CNT_W-1:0] scol_e, srow_e;
    logic [TGT_CNT_W-1:0] tcol_e, trow_e;
    logic [NSP_W-1:0]     nsc_e, nsr_e;
    logic [REM_W-1:0]     crem_e, rrem_e;
    logic [GRAY_W-1:0]    prev_e;
    logic [HASH_W-1:0]    hash_e;

    logic [REM_W:0]       csum, rsum;
    logic                 ccarry, rcarry;
    logic [CNT_PROD_W-1:0] cmp_count;
    logic                 bad;
    logic [SRC_CNT_W-1:0] esw_m1, esh_m1;
    logic                 row_sample, col_sample, row_end, frame_end;

    function automatic logic [HASH_W-1:0] hash_next_out(
        input logic [HASH_W-1:0]    h,
        input logic [GRAY_W-1:0]    p,
        input logic [GRAY_W-1:0]    g,
        input logic                 smp,
        input logic [TGT_CNT_W-1:0] tc
    );
        logic [HASH_W-1:0] r;
        r = h;
        if (smp && tc != '0)
            r = {h[HASH_W-2:0], p < g};
        return r;
    endfunction

    scd_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.cfg_we),
        .dividend_a (sw_reg),
        .divisor_a  (tw_reg),
        .dividend_b (sh_reg),
        .divisor_b  (th_reg),
        .quot_a     (quot_w),
        .rem_a      (rem_w),
        .quot_b     (quot_h),
        .rem_b      (rem_h),
        .done       (sts.div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= SRC_CFG_W'(RST_SW);
            sh_reg <= SRC_CFG_W'(RST_SH);
            tw_reg <= TGT_CFG_W'(RST_TW);
            th_reg <= TGT_CFG_W'(RST_TH);
        end
        else if (cmd.cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                CFG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                CFG_TARGET_WIDTH:  tw_reg <= cfg_data[TGT_CFG_W-1:0];
                CFG_TARGET_HEIGHT: th_reg <= cfg_data[TGT_CFG_W-1:0];
                default:           sw_reg <= sw_reg;
            endcase
        end
    end

    // luma weights, then divide by 1000 through a reciprocal
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wsum_reg  <= WSUM_W'(GRAY_K0) * WSUM_W'(pixel[0*BYTE_W +: BYTE_W])
                       + WSUM_W'(GRAY_K1) * WSUM_W'(pixel[1*BYTE_W +: BYTE_W])
                       + WSUM_W'(GRAY_K2) * WSUM_W'(pixel[2*BYTE_W +: BYTE_W]);
            first_reg <= frame_first;
        end
        if (cmd.gray_en)
        begin
            gray_reg <= prod[RECIP_SHIFT +: GRAY_W];
        end
    end

    assign prod = PROD_W'(wsum_reg) * PROD_W'(RECIP_MUL);

    always_comb
    begin
        cmp_count = CNT_PROD_W'(tw_reg - 1'b1) * CNT_PROD_W'(th_reg);
        bad = sw_reg == '0 || sh_reg == '0 || tw_reg == '0 || th_reg == '0
           || sw_reg > SRC_CFG_W'(MAX_SOURCE_DIM) || sh_reg > SRC_CFG_W'(MAX_SOURCE_DIM)
           || tw_reg > TGT_CFG_W'(MAX_TARGET_DIM) || th_reg > TGT_CFG_W'(MAX_TARGET_DIM)
           || SRC_CFG_W'(tw_reg) > sw_reg || SRC_CFG_W'(th_reg) > sh_reg
           || cmp_count > CNT_PROD_W'(HASH_W);

        if (sw_reg == '0)
            esw_m1 = '0;
        else if (sw_reg > SRC_CFG_W'(MAX_SOURCE_DIM))
            esw_m1 = SRC_CNT_W'(MAX_SOURCE_DIM - 1);
        else
            esw_m1 = SRC_CNT_W'(sw_reg - 1'b1);

        if (sh_reg == '0)
            esh_m1 = '0;
        else if (sh_reg > SRC_CFG_W'(MAX_SOURCE_DIM))
            esh_m1 = SRC_CNT_W'(MAX_SOURCE_DIM - 1);
        else
            esh_m1 = SRC_CNT_W'(sh_reg - 1'b1);
    end

    // state as seen by this pixel, after a frame restart
    always_comb
    begin
        scol_e = first_reg ? '0 : scol_reg;
        srow_e = first_reg ? '0 : srow_reg;
        tcol_e = first_reg ? '0 : tcol_reg;
        trow_e = first_reg ? '0 : trow_reg;
        nsc_e  = first_reg ? '0 : nsc_reg;
        nsr_e  = first_reg ? '0 : nsr_reg;
        crem_e = first_reg ? '0 : crem_reg;
        rrem_e = first_reg ? '0 : rrem_reg;
        prev_e = first_reg ? '0 : prev_reg;
        hash_e = first_reg ? '0 : hash_reg;
    end

    always_comb
    begin
        row_sample = !bad && trow_e < th_reg && NSP_W'(srow_e) == nsr_e;
        col_sample = row_sample && tcol_e < tw_reg && NSP_W'(scol_e) == nsc_e;
        row_end    = scol_e >= esw_m1;
        frame_end  = row_end && srow_e >= esh_m1;

        csum   = {1'b0, crem_e} + {1'b0, rem_w};
        ccarry = csum >= {1'b0, tw_reg};
        rsum   = {1'b0, rrem_e} + {1'b0, rem_h};
        rcarry = rsum >= {1'b0, th_reg};

        scol_next = scol_e;
        srow_next = srow_e;
        tcol_next = tcol_e;
        trow_next = trow_e;
        nsc_next  = nsc_e;
        nsr_next  = nsr_e;
        crem_next = crem_e;
        rrem_next = rrem_e;
        prev_next = prev_e;
        hash_next = hash_e;

        if (col_sample)
        begin
            if (tcol_e != '0)
                hash_next = {hash_e[HASH_W-2:0], prev_e < gray_reg};
            prev_next = gray_reg;
            tcol_next = tcol_e + 1'b1;
            // past the last column it can never match again, so hold
            if (nsc_e < NSP_W'(MAX_SOURCE_DIM))
                nsc_next = NSP_W'(nsc_e + quot_w + ccarry);
            crem_next = ccarry ? REM_W'(csum - {1'b0, tw_reg}) : csum[REM_W-1:0];
        end

        if (frame_end)
        begin
            scol_next = '0;
            srow_next = '0;
            tcol_next = '0;
            trow_next = '0;
            nsc_next  = '0;
            nsr_next  = '0;
            crem_next = '0;
            rrem_next = '0;
            prev_next = '0;
            hash_next = '0;
        end
        else if (row_end)
        begin
            if (row_sample)
            begin
                trow_next = trow_e + 1'b1;
                if (nsr_e < NSP_W'(MAX_SOURCE_DIM))
                    nsr_next = NSP_W'(nsr_e + quot_h + rcarry);
                rrem_next = rcarry ? REM_W'(rsum - {1'b0, th_reg}) : rsum[REM_W-1:0];
            end
            scol_next = '0;
            tcol_next = '0;
            nsc_next  = '0;
            crem_next = '0;
            srow_next = srow_e + 1'b1;
        end
        else
        begin
            scol_next = scol_e + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg <= '0;
            srow_reg <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            nsc_reg  <= '0;
            nsr_reg  <= '0;
            crem_reg <= '0;
            rrem_reg <= '0;
            prev_reg <= '0;
            hash_reg <= '0;
        end
        else if (cmd.update)
        begin
            scol_reg <= scol_next;
            srow_reg <= srow_next;
            tcol_reg <= tcol_next;
            trow_reg <= trow_next;
            nsc_reg  <= nsc_next;
            nsr_reg  <= nsr_next;
            crem_reg <= crem_next;
            rrem_reg <= rrem_next;
            prev_reg <= prev_next;
            hash_reg <= hash_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.update && frame_end)
        begin
            hash      <= bad ? '0 : hash_next_out(hash_e, prev_e, gray_reg, col_sample, tcol_e);
            bad_setup <= bad;
        end
    end

    assign sts.frame_end = frame_end;

endmodule

`default_nettype wire

// ===== rtl/scd_ctrl.sv =====
`default_nettype none

module scd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               m_ready,
    output logic                    m_valid,
    input  wire scd_pkg::scd_sts_t  sts,
    output scd_pkg::scd_cmd_t       cmd
);
    import scd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_GRAY = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   stall;

    assign cfg_ready = state_reg == ST_IDLE || state_reg == ST_DIV;
    assign s_ready   = state_reg == ST_IDLE && !cfg_valid;
    assign stall     = sts.frame_end && m_valid_reg && !m_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.cfg_we  = cfg_valid && cfg_ready;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.cfg_we)
                    state_next = ST_DIV;
                else if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GRAY;
                end
            end
            ST_DIV:
            begin
                if (!cmd.cfg_we && sts.div_done)
                    state_next = ST_IDLE;
            end
            ST_GRAY:
            begin
                cmd.gray_en = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                if (!stall)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || (cmd.update && sts.frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
